// ===== hw/rtl/vt100_pkg.sv =====
// vt100_pkg: command codes, sizes and the queue entry type of the escape parser
// depends on nothing
package vt100_pkg;

    localparam logic [4:0] CMD_PRINT  = 5'd0;
    localparam logic [4:0] CMD_CR     = 5'd1;
    localparam logic [4:0] CMD_LF     = 5'd2;
    localparam logic [4:0] CMD_BS     = 5'd3;
    localparam logic [4:0] CMD_BEEP   = 5'd4;
    localparam logic [4:0] CMD_MOVE   = 5'd5;
    localparam logic [4:0] CMD_SETPOS = 5'd6;
    localparam logic [4:0] CMD_EL_END = 5'd7;
    localparam logic [4:0] CMD_EL_BEG = 5'd8;
    localparam logic [4:0] CMD_EL_ALL = 5'd9;
    localparam logic [4:0] CMD_ES_END = 5'd10;
    localparam logic [4:0] CMD_ES_BEG = 5'd11;
    localparam logic [4:0] CMD_ES_ALL = 5'd12;
    localparam logic [4:0] CMD_FORMAT = 5'd13;
    localparam logic [4:0] CMD_SCROLL = 5'd14;
    localparam logic [4:0] CMD_SINGLE = 5'd15;
    localparam logic [4:0] CMD_DOUBLE = 5'd16;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_SI  = 8'h0F;

    localparam int ARG_W = 9;
    localparam int OUT_W = 34;

    // front-to-back queue entry
    typedef struct packed {
        logic       is_esc;
        logic [7:0] ch;
    } t_entry;

    typedef struct packed {
        logic [4:0] cmd;
        logic [8:0] a;
        logic [8:0] b;
        logic [7:0] glyph;
        logic [2:0] mask;
        logic       on;
    } t_result;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

// ===== hw/rtl/vt100_ram.sv =====
// vt100_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing
module vt100_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/vt100_front.sv =====
// vt100_front: takes bytes, handles printing-mode bytes, tags escape bytes
// depends on vt100_pkg
module vt100_front
    import vt100_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic [7:0] i_byte,
    input  logic    i_esc_done,
    output logic    o_q_valid,
    input  logic    i_q_ready,
    output t_entry  o_q_data
);
    logic r_esc;
    logic n_esc;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_entry r_q [2];
    logic r_wp, r_rp;
    logic take, pop, esc_now;

    // in escape mode, one byte at a time until the back part has judged it
    assign esc_now = r_esc && !i_esc_done;
    assign o_ready = (r_cnt != 2'd2) && !(esc_now && (r_cnt != 2'd0 || !i_q_ready));
    assign take = i_valid && o_ready;
    assign pop = o_q_valid && i_q_ready;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_data = r_q[r_rp];

    always_comb begin
        n_esc = r_esc;
        if (i_esc_done) begin
            n_esc = 1'b0;
        end
        if (take && !esc_now && i_byte == CH_ESC) begin
            n_esc = 1'b1;
        end
        n_cnt = r_cnt + {1'b0, take} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wp] <= '{is_esc: esc_now, ch: i_byte};
        end
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_esc <= n_esc;
            r_cnt <= n_cnt;
            if (take) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
        end
    end
endmodule

// ===== hw/rtl/vt100_back.sv =====
// vt100_back: sequence buffer and rescan matcher, produces command words
// depends on vt100_pkg, vt100_ram
module vt100_back
    import vt100_pkg::*;
#(
    parameter int SEQ_DEPTH = 16,
    parameter int PARAM_MAX = 255
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    output logic    o_q_ready,
    input  t_entry  i_q_data,
    output logic    o_esc_done,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);
    localparam int AW = $clog2(SEQ_DEPTH);
    localparam int LW = $clog2(SEQ_DEPTH + 1);
    localparam int PW = $clog2(PARAM_MAX + 1);
    localparam logic [PW-1:0] PMAX = PW'(PARAM_MAX);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_st, n_st;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_n;
    logic [AW:0] r_pos;
    logic [7:0] r_first, r_second, r_prev, r_last;
    logic [PW-1:0] r_va, r_vb;
    logic r_anya, r_anyb, r_insec, r_stop;
    logic r_ovf;
    t_result r_res, n_res;
    logic r_emit;
    logic [7:0] rdata;
    logic [AW-1:0] raddr;
    logic we;

    assign raddr = r_pos[AW-1:0];
    assign we = i_q_valid && o_q_ready && i_q_data.is_esc && !r_ovf;

    vt100_ram #(.WIDTH(8), .DEPTH(SEQ_DEPTH)) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_q_data.ch),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_q_ready = (r_st == S_IDLE) && !(o_valid && !i_ready);
    assign o_valid = r_emit;
    assign o_res = r_res;

    function automatic logic [PW-1:0] step_num(input logic [PW-1:0] v, input logic [7:0] c);
        logic [PW+3:0] t;
        t = {4'd0, v} * (PW+4)'(10) + {{PW{1'b0}}, c[3:0]};
        step_num = (t > {4'd0, PMAX}) ? PMAX : t[PW-1:0];
    endfunction

    function automatic logic [8:0] arg(input logic [PW-1:0] v, input logic any);
        arg = any ? 9'(v) : 9'd1;
    endfunction

    logic [8:0] a9, b9;
    logic ok_res;
    logic hit, emit;

    always_comb begin
        a9 = arg(r_va, r_anya);
        b9 = arg(r_vb, r_anyb);
        hit = 1'b1;
        emit = 1'b0;
        n_res = '0;
        if (r_first == 8'h5B) begin
            case (r_last)
                8'h41: begin emit = 1'b1; n_res.cmd = CMD_MOVE; n_res.a = -a9; end
                8'h42: begin emit = 1'b1; n_res.cmd = CMD_MOVE; n_res.a = a9; end
                8'h43: begin emit = 1'b1; n_res.cmd = CMD_MOVE; n_res.b = a9; end
                8'h44: begin emit = 1'b1; n_res.cmd = CMD_MOVE; n_res.b = -a9; end
                8'h48, 8'h66: begin
                    emit = 1'b1; n_res.cmd = CMD_SETPOS;
                    n_res.a = a9 - 9'd1; n_res.b = b9 - 9'd1;
                end
                8'h72: begin emit = 1'b1; n_res.cmd = CMD_SCROLL; n_res.a = a9; n_res.b = b9; end
                8'h4B: begin
                    emit = 1'b1;
                    if (r_second == 8'h4B) n_res.cmd = CMD_EL_END;
                    else if (r_second == 8'h31) n_res.cmd = CMD_EL_BEG;
                    else if (r_second == 8'h32) n_res.cmd = CMD_EL_ALL;
                    else begin emit = 1'b0; hit = 1'b0; end
                end
                8'h4A: begin
                    emit = 1'b1;
                    if (r_second == 8'h4A) n_res.cmd = CMD_ES_END;
                    else if (r_second == 8'h31) n_res.cmd = CMD_ES_BEG;
                    else if (r_second == 8'h32) n_res.cmd = CMD_ES_ALL;
                    else begin emit = 1'b0; hit = 1'b0; end
                end
                8'h6D: begin
                    n_res.cmd = CMD_FORMAT; emit = 1'b1;
                    if (r_second == 8'h6D) n_res.mask = 3'd7;
                    else if (r_second == 8'h31) begin n_res.mask = 3'd1; n_res.on = 1'b1; end
                    else if (r_second == 8'h34) begin n_res.mask = 3'd2; n_res.on = 1'b1; end
                    else if (r_second == 8'h37) begin n_res.mask = 3'd4; n_res.on = 1'b1; end
                    else emit = 1'b0;
                end
                8'h68, 8'h6C: hit = 1'b1;
                8'h67: hit = (r_second == 8'h67 || r_second == 8'h30 || r_second == 8'h33);
                8'h6E: hit = (r_second == 8'h35 || r_second == 8'h36);
                default: hit = 1'b0;
            endcase
        end else begin
            case (r_first)
                8'h45: begin emit = 1'b1; n_res.cmd = CMD_LF; end
                8'h44, 8'h4D, 8'h37, 8'h38, 8'h3D, 8'h3E, 8'h48: hit = 1'b1;
                8'h23: begin
                    if (r_n < LW'(2)) hit = 1'b0;
                    else if (r_second == 8'h35) begin emit = 1'b1; n_res.cmd = CMD_SINGLE; end
                    else if (r_second == 8'h37) begin emit = 1'b1; n_res.cmd = CMD_DOUBLE; end
                end
                default: hit = is_letter(r_last);
            endcase
        end
        if (!emit) n_res = '0;
        ok_res = emit;
    end

    logic [7:0] qc;
    assign qc = i_q_data.ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_len <= '0;
            r_emit <= 1'b0;
            r_ovf <= 1'b0;
            o_esc_done <= 1'b0;
        end else begin
            o_esc_done <= 1'b0;
            if (r_emit && i_ready) r_emit <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_q_valid && o_q_ready) begin
                        if (!i_q_data.is_esc) begin
                            if (qc != CH_ESC && qc != CH_SI) begin
                                r_emit <= 1'b1;
                                r_res <= '0;
                                case (qc)
                                    CH_CR:  r_res.cmd <= CMD_CR;
                                    CH_LF:  r_res.cmd <= CMD_LF;
                                    CH_BS:  r_res.cmd <= CMD_BS;
                                    CH_BEL: r_res.cmd <= CMD_BEEP;
                                    default: r_res.glyph <= qc;
                                endcase
                            end
                        end else if (r_ovf) begin
                            r_ovf <= 1'b0;
                            r_len <= '0;
                            o_esc_done <= 1'b1;
                        end else begin
                            r_last <= qc;
                            r_n <= r_len + LW'(1);
                            r_pos <= '0;
                            r_va <= '0; r_vb <= '0;
                            r_anya <= 1'b0; r_anyb <= 1'b0;
                            r_insec <= 1'b0; r_stop <= 1'b0;
                            r_second <= 8'd0;
                            r_st <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // one buffer byte a cycle; data of r_pos arrives next cycle
                    r_pos <= r_pos + (AW+1)'(1);
                    if (r_pos != '0) begin
                        if (r_pos == (AW+1)'(1)) r_first <= rdata;
                        if (r_pos == (AW+1)'(2)) r_second <= rdata;
                        if (r_pos >= (AW+1)'(2) && !r_stop) begin
                            if (is_digit(rdata)) begin
                                if (r_insec) begin r_vb <= step_num(r_vb, rdata); r_anyb <= 1'b1; end
                                else begin r_va <= step_num(r_va, rdata); r_anya <= 1'b1; end
                            end else if (!r_insec && rdata == 8'h3B) r_insec <= 1'b1;
                            else r_stop <= 1'b1;
                        end
                        if (LW'(r_pos) == r_n) r_st <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!(r_emit && !i_ready)) begin
                        r_st <= S_IDLE;
                        if (hit) begin
                            r_len <= '0;
                            o_esc_done <= 1'b1;
                            if (ok_res) begin r_emit <= 1'b1; r_res <= n_res; end
                        end else begin
                            r_len <= r_n;
                            if (r_n == LW'(SEQ_DEPTH)) begin
                                r_len <= '0;
                                o_esc_done <= 1'b1;
                            end
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/vt100_escape_parser.sv =====
// vt100_escape_parser: top level of the byte-serial escape sequence parser
// depends on vt100_pkg, vt100_front, vt100_back
//  channel  | dir | tdata bits           | tuser
//  s_axis   | in  | [7:0] rx_byte        | none
//  m_axis   | out | [4:0] cmd [13:5] first_arg [22:14] second_arg
//           |     | [30:23] glyph [33:31] attr_mask [34] attr_on [39:35] zero | none
// a printing byte passes the front queue and then the registered result word;
// one byte a cycle while the output is not stalled; an escape byte holds the input
// until the back part has judged it, set by the one-byte-a-cycle rescan of the buffer ram
// reset is synchronous, active low; no clearing pass
// a stalled output holds the back part and, in escape mode, the input
module vt100_escape_parser
    import vt100_pkg::*;
#(
    parameter int SEQ_DEPTH = 16,
    parameter int PARAM_MAX = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // cmd, first_arg, second_arg, glyph, attr_mask, attr_on
);
    logic q_valid, q_ready, esc_done;
    t_entry q_data;
    t_result res;

    vt100_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_byte(s_axis_tdata),
        .i_esc_done(esc_done),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_data(q_data)
    );

    vt100_back #(.SEQ_DEPTH(SEQ_DEPTH), .PARAM_MAX(PARAM_MAX)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_data(q_data),
        .o_esc_done(esc_done),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {5'd0, res.on, res.mask, res.glyph, res.b, res.a, res.cmd};
endmodule

// ===== hw/rtl/vt100_checker.sv =====
// vt100_checker: port-level assertions for the escape parser
// depends on vt100_escape_parser
module vt100_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped under stall");
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= 5'd16)
        else $error("bad command code");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
        else $error("pad bits set");
    a_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4:0] != 5'd0 |-> m_axis_tdata[30:23] == 8'd0)
        else $error("glyph on non-print command");
endmodule

bind vt100_escape_parser vt100_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== tb/tb_vt100_escape_parser.sv =====
// tb_vt100_escape_parser: self-checking stream testbench for the escape sequence parser
// depends on vt100_pkg and vt100_escape_parser; predicts each command word and compares
// field by field, with random idling on both stream sides
module tb_vt100_escape_parser;
    import vt100_pkg::*;

    localparam int DEPTH = 16;
    localparam int PMAX = 255;
    localparam int LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    vt100_escape_parser u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic       esc_mode;
    int         seq_cnt;
    logic [7:0] seq_buf [DEPTH];

    t_result    cmd_q [$];
    logic [7:0] byte_q [$];
    int         errors = 0;
    int         cycles = 0;
    int         n_cmds = 0;
    bit         idle_on = 1'b1;
    bit         hold_tx = 1'b0;
    bit         in_taken = 1'b0;

    function automatic t_result mk(int c, int a, int b, int g, int m, int o);
        t_result r;
        r.cmd = 5'(c); r.a = 9'(a); r.b = 9'(b); r.glyph = 8'(g); r.mask = 3'(m);
        r.on = 1'(o);
        return r;
    endfunction

    function automatic int parse_num(int n, inout int pos);
        int v;
        bit any;
        v = 0;
        any = 0;
        while (pos < n && seq_buf[pos] >= "0" && seq_buf[pos] <= "9") begin
            v = v * 10 + (seq_buf[pos] - "0");
            if (v > PMAX) v = PMAX;
            any = 1;
            pos++;
        end
        return any ? v : 1;
    endfunction

    // returns -1 while partial, else the number of commands
    function automatic int match_seq(int n, output t_result r);
        logic [7:0] f, l, s;
        int a, b, p;
        f = seq_buf[0];
        l = seq_buf[n-1];
        s = (n > 1) ? seq_buf[1] : 8'h00;
        p = 1;
        r = '0;
        case (f)
            "[": begin
                case (l)
                    "A": begin a = parse_num(n, p); r = mk(CMD_MOVE, -a, 0, 0, 0, 0); return 1; end
                    "B": begin a = parse_num(n, p); r = mk(CMD_MOVE, a, 0, 0, 0, 0); return 1; end
                    "C": begin a = parse_num(n, p); r = mk(CMD_MOVE, 0, a, 0, 0, 0); return 1; end
                    "D": begin a = parse_num(n, p); r = mk(CMD_MOVE, 0, -a, 0, 0, 0); return 1; end
                    "H", "f", "r": begin
                        a = parse_num(n, p);
                        b = 1;
                        if (p < n && seq_buf[p] == ";") begin
                            p++;
                            b = parse_num(n, p);
                        end
                        if (l == "r") r = mk(CMD_SCROLL, a, b, 0, 0, 0);
                        else r = mk(CMD_SETPOS, a - 1, b - 1, 0, 0, 0);
                        return 1;
                    end
                    "K": begin
                        if (s == "K") begin r = mk(CMD_EL_END, 0, 0, 0, 0, 0); return 1; end
                        if (s == "1") begin r = mk(CMD_EL_BEG, 0, 0, 0, 0, 0); return 1; end
                        if (s == "2") begin r = mk(CMD_EL_ALL, 0, 0, 0, 0, 0); return 1; end
                        return -1;
                    end
                    "J": begin
                        if (s == "J") begin r = mk(CMD_ES_END, 0, 0, 0, 0, 0); return 1; end
                        if (s == "1") begin r = mk(CMD_ES_BEG, 0, 0, 0, 0, 0); return 1; end
                        if (s == "2") begin r = mk(CMD_ES_ALL, 0, 0, 0, 0, 0); return 1; end
                        return -1;
                    end
                    "m": begin
                        if (s == "m") begin r = mk(CMD_FORMAT, 0, 0, 0, 7, 0); return 1; end
                        if (s == "1") begin r = mk(CMD_FORMAT, 0, 0, 0, 1, 1); return 1; end
                        if (s == "4") begin r = mk(CMD_FORMAT, 0, 0, 0, 2, 1); return 1; end
                        if (s == "7") begin r = mk(CMD_FORMAT, 0, 0, 0, 4, 1); return 1; end
                        return 0;
                    end
                    "h", "l": return 0;
                    "g": return (s == "g" || s == "0" || s == "3") ? 0 : -1;
                    "n": return (s == "5" || s == "6") ? 0 : -1;
                    default: return -1;
                endcase
            end
            "E": begin r = mk(CMD_LF, 0, 0, 0, 0, 0); return 1; end
            "D", "M", "7", "8", "=", ">", "H": return 0;
            "#": begin
                if (n < 2) return -1;
                if (s == "5") begin r = mk(CMD_SINGLE, 0, 0, 0, 0, 0); return 1; end
                if (s == "7") begin r = mk(CMD_DOUBLE, 0, 0, 0, 0, 0); return 1; end
                return 0;
            end
            default: return ((l >= "A" && l <= "Z") || (l >= "a" && l <= "z")) ? 0 : -1;
        endcase
    endfunction

    function automatic void clear_seq();
        foreach (seq_buf[i]) seq_buf[i] = 8'h00;
        seq_cnt = 0;
        esc_mode = 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        t_result r;
        int k;
        if (!esc_mode) begin
            case (c)
                CH_ESC: esc_mode = 1'b1;
                CH_CR:  cmd_q.push_back(mk(CMD_CR, 0, 0, 0, 0, 0));
                CH_LF:  cmd_q.push_back(mk(CMD_LF, 0, 0, 0, 0, 0));
                CH_BS:  cmd_q.push_back(mk(CMD_BS, 0, 0, 0, 0, 0));
                CH_BEL: cmd_q.push_back(mk(CMD_BEEP, 0, 0, 0, 0, 0));
                CH_SI:  ;
                default: cmd_q.push_back(mk(CMD_PRINT, 0, 0, c, 0, 0));
            endcase
            return;
        end
        if (seq_cnt >= DEPTH) begin
            clear_seq();
            return;
        end
        seq_buf[seq_cnt] = c;
        k = match_seq(seq_cnt + 1, r);
        if (k < 0) begin
            seq_cnt++;
            if (seq_cnt >= DEPTH) clear_seq();
            return;
        end
        clear_seq();
        if (k > 0) cmd_q.push_back(r);
    endfunction

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
    endtask

    task automatic push_esc(string s);
        byte_q.push_back(CH_ESC);
        push_str(s);
    endtask

    function automatic string rand_num();
        int k;
        k = $urandom_range(0, 5);
        if (k == 0) return "";
        if (k == 1) return "0";
        if (k == 2) return "999";
        return $sformatf("%0d", $urandom_range(1, 300));
    endfunction

    task automatic push_random_seq();
        string fins = "ABCDHfrKJmhlgn";
        string p;
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) begin
            p = rand_num();
            if ($urandom_range(0, 1)) p = {p, ";", rand_num()};
            case ($urandom_range(0, 3))
                0: p = {string'(8'($urandom_range(48, 57))), ""};
                1: p = {"", "", p};
                default: ;
            endcase
            push_esc({"[", p, string'(fins[$urandom_range(0, fins.len() - 1)])});
        end else if (k == 5) begin
            byte_q.push_back(CH_ESC);
            byte_q.push_back("#");
            byte_q.push_back(8'($urandom_range(0, 255)));
        end else if (k == 6) begin
            byte_q.push_back(CH_ESC);
            byte_q.push_back(8'($urandom_range(0, 255)));
        end else if (k == 7) begin
            // broken or overlong sequence
            byte_q.push_back(CH_ESC);
            repeat ($urandom_range(1, 20)) byte_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // driver
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_taken) begin
                // word still waiting
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (byte_q.size() > 0 && !hold_tx) begin
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    tx_gap <= $urandom_range(0, 5);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= byte_q[0];
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            in_taken = 1'b0;
        end
    end

    // output ready with random stalls
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got, want;
        cycles <= cycles + 1;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_byte(s_axis_tdata);
            void'(byte_q.pop_front());
            in_taken = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cmd = m_axis_tdata[4:0];
            got.a = m_axis_tdata[13:5];
            got.b = m_axis_tdata[22:14];
            got.glyph = m_axis_tdata[30:23];
            got.mask = m_axis_tdata[33:31];
            got.on = m_axis_tdata[34];
            n_cmds <= n_cmds + 1;
            if (cmd_q.size() == 0) begin
                $error("unexpected word cmd=%0d", got.cmd);
                errors++;
            end else begin
                want = cmd_q.pop_front();
                if (got.cmd !== want.cmd) begin
                    $error("cmd: expected %0d got %0d", want.cmd, got.cmd); errors++;
                end
                if (got.a !== want.a) begin
                    $error("first_arg: expected %0h got %0h", want.a, got.a); errors++;
                end
                if (got.b !== want.b) begin
                    $error("second_arg: expected %0h got %0h", want.b, got.b); errors++;
                end
                if (got.glyph !== want.glyph) begin
                    $error("glyph: expected %0h got %0h", want.glyph, got.glyph);
                    errors++;
                end
                if (got.mask !== want.mask) begin
                    $error("attr_mask: expected %0d got %0d", want.mask, got.mask);
                    errors++;
                end
                if (got.on !== want.on) begin
                    $error("attr_on: expected %0d got %0d", want.on, got.on); errors++;
                end
                if (m_axis_tdata[39:35] !== 5'd0) begin
                    $error("pad: expected 0 got %0h", m_axis_tdata[39:35]); errors++;
                end
            end
        end
        if (cycles >= LIMIT) begin
            $display("timeout with %0d words pending", cmd_q.size());
            $display("vt100_escape_parser test failed");
            $finish;
        end
    end

    task automatic wait_drain();
        while (byte_q.size() > 0 || cmd_q.size() > 0) @(posedge i_clk);
        repeat (2 * DEPTH + 10) @(posedge i_clk);
    endtask

    initial begin
        clear_seq();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed part
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(CH_CR);
        byte_q.push_back(CH_LF);
        byte_q.push_back(CH_BS);
        byte_q.push_back(CH_BEL);
        byte_q.push_back(CH_SI);
        push_esc("[A"); push_esc("[999B"); push_esc("[0C"); push_esc("[12D");
        push_esc("[H"); push_esc("[5;300f"); push_esc("[0;0H"); push_esc("[3;7r");
        push_esc("[K"); push_esc("[1K"); push_esc("[2K"); push_esc("[J");
        push_esc("[1J"); push_esc("[2J"); push_esc("[m"); push_esc("[1m");
        push_esc("[4m"); push_esc("[7m"); push_esc("[9m"); push_esc("[?1h");
        push_esc("[?9l"); push_esc("[g"); push_esc("[3g"); push_esc("[6n");
        push_esc("[5K");
        push_esc("E"); push_esc("#5"); push_esc("#7"); push_esc("#2"); push_esc("#x");
        push_esc("D"); push_esc("M"); push_esc("7"); push_esc("8"); push_esc("=");
        push_esc(">"); push_esc("H"); push_esc("(B"); push_esc("[12345678901234567");
        byte_q.push_back("Z");
        wait_drain();

        // hold-off after draining, then random traffic
        hold_tx = 1'b1;
        repeat (20) @(posedge i_clk);
        hold_tx = 1'b0;
        while (byte_q.size() < 340) push_random_seq();
        while (byte_q.size() > 120) @(posedge i_clk);
        idle_on = 1'b0;
        wait_drain();

        $display("covered plain bytes, control codes, cursor, erase, format, scroll");
        $display("and line-width sequences plus broken and overlong ones; %0d words", n_cmds);
        if (errors == 0 && cmd_q.size() == 0)
            $display("vt100_escape_parser test passed");
        else
            $display("vt100_escape_parser test failed");
        $finish;
    end
endmodule
